[hdl/gbc_pkg.sv]
// shared types and constants of the 3x3 binomial blur
package gbc_pkg;

  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned VSUM_W      = CHAN_W + 2;
  localparam int unsigned HSUM_W      = CHAN_W + 4;
  localparam int unsigned WIDTH_W     = 12;
  localparam int unsigned WIDTH_REG_W = WIDTH_W + 1;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned CMP_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned FIFO_DEPTH  = 8;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW     = FIFO_AW + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // the register has one bit more than the 12-bit configured field; a written width is zero-extended
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 13'd2048;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd1;

  // channel 3 alpha, 2 red, 1 green, 0 blue
  typedef logic [3:0][CHAN_W-1:0] pixel_t;
  typedef logic [3:0][VSUM_W-1:0] vsum_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_t;

  typedef struct packed {
    logic   valid;
    logic   row0;
    logic   flushing;
    logic   col_zero;
    logic   emit_mid;
    logic   emit_last;
    pixel_t pix;
  } stage_t;

  typedef struct packed {
    pixel_t px;
    logic   eor;
    logic   eof;
  } result_t;

  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t res_a;
    result_t res_b;
  } push_t;

endpackage

[hdl/gbc_in_if.sv]
// input request channel of the blur
interface gbc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [gbc_pkg::CHAN_W-1:0] pixel_alpha;
  logic [gbc_pkg::CHAN_W-1:0] pixel_red;
  logic [gbc_pkg::CHAN_W-1:0] pixel_green;
  logic [gbc_pkg::CHAN_W-1:0] pixel_blue;

  modport source (
    output valid, req_type, pixel_alpha, pixel_red, pixel_green, pixel_blue,
    input  ready
  );
  modport sink (
    input  valid, req_type, pixel_alpha, pixel_red, pixel_green, pixel_blue,
    output ready
  );
endinterface

[hdl/gbc_out_if.sv]
// result channel of the blur
interface gbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [gbc_pkg::CHAN_W-1:0] out_alpha;
  logic [gbc_pkg::CHAN_W-1:0] out_red;
  logic [gbc_pkg::CHAN_W-1:0] out_green;
  logic [gbc_pkg::CHAN_W-1:0] out_blue;
  logic                        end_of_row;
  logic                        end_of_frame;

  modport source (
    output valid, out_alpha, out_red, out_green, out_blue, end_of_row, end_of_frame,
    input  ready
  );
  modport sink (
    input  valid, out_alpha, out_red, out_green, out_blue, end_of_row, end_of_frame,
    output ready
  );
endinterface

[hdl/gbc_line_store.sv]
// two line stores packed into one synchronous memory with write forwarding
module gbc_line_store #(
  parameter int unsigned Depth = gbc_pkg::MAX_WIDTH,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  gbc_pkg::line_t        wr_data_i,
  output gbc_pkg::line_t        rd_data_o
);

  gbc_pkg::line_t mem_q [Depth];
  gbc_pkg::line_t rd_q;
  gbc_pkg::line_t fwd_data_q;
  logic           fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
    fwd_data_q <= wr_data_i;
  end

  // read and write of the same entry in one cycle: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

[hdl/gbc_window.sv]
// 3x3 window of column sums and the two blur results of one request
module gbc_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbc_pkg::stage_t  stage_i,
  input  gbc_pkg::pixel_t  upper_i,
  input  gbc_pkg::pixel_t  middle_i,
  output gbc_pkg::push_t   push_o
);

  function automatic gbc_pkg::vsum_t vert_sum(gbc_pkg::pixel_t t, gbc_pkg::pixel_t m,
                                              gbc_pkg::pixel_t b);
    gbc_pkg::vsum_t s;
    for (int ch = 0; ch < 4; ch++) begin
      s[ch] = {2'b00, t[ch]} + {1'b0, m[ch], 1'b0} + {2'b00, b[ch]};
    end
    return s;
  endfunction

  function automatic gbc_pkg::pixel_t blur(gbc_pkg::vsum_t l, gbc_pkg::vsum_t c,
                                           gbc_pkg::vsum_t r);
    gbc_pkg::pixel_t             o;
    logic [gbc_pkg::HSUM_W-1:0] h;
    for (int ch = 0; ch < 4; ch++) begin
      h     = {2'b00, l[ch]} + {1'b0, c[ch], 1'b0} + {2'b00, r[ch]};
      o[ch] = h[gbc_pkg::HSUM_W-1:4];
    end
    return o;
  endfunction

  gbc_pkg::pixel_t pix;
  gbc_pkg::vsum_t  v;
  gbc_pkg::vsum_t  left;
  gbc_pkg::vsum_t  centre;
  gbc_pkg::vsum_t  c1_q;
  gbc_pkg::vsum_t  c2_q;

  // on flush the row below repeats the middle row
  assign pix    = stage_i.flushing ? middle_i : stage_i.pix;
  assign v      = vert_sum(upper_i, middle_i, pix);
  assign left   = stage_i.col_zero ? v : c1_q;
  assign centre = stage_i.col_zero ? v : c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else if (stage_i.valid && !stage_i.row0) begin
      c1_q <= centre;
      c2_q <= v;
    end
  end

  always_comb begin
    push_o.push_a    = stage_i.valid && stage_i.emit_mid;
    push_o.push_b    = stage_i.valid && stage_i.emit_last;
    push_o.res_a.px  = blur(left, centre, v);
    push_o.res_a.eor = 1'b0;
    push_o.res_a.eof = 1'b0;
    push_o.res_b.px  = blur(centre, v, v);
    push_o.res_b.eor = 1'b1;
    push_o.res_b.eof = stage_i.flushing;
  end

endmodule

[hdl/gbc_out_fifo.sv]
// result queue taking up to two results a cycle
module gbc_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbc_pkg::push_t                push_i,
  output logic [gbc_pkg::FIFO_CW-1:0]  count_o,
  gbc_out_if.source                     res_o
);

  localparam int unsigned Aw = gbc_pkg::FIFO_AW;
  localparam int unsigned Cw = gbc_pkg::FIFO_CW;

  gbc_pkg::result_t mem_q [gbc_pkg::FIFO_DEPTH];
  logic [Aw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [Cw-1:0]    count_q, count_d;
  logic [Aw-1:0]    wr_ptr_b;
  logic [1:0]       n_push;
  logic             pop;

  assign pop      = res_o.valid && res_o.ready;
  assign n_push   = {1'b0, push_i.push_a} + {1'b0, push_i.push_b};
  assign wr_ptr_b = push_i.push_a ? Aw'(wr_ptr_q + 1'b1) : wr_ptr_q;

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.push_b) begin
      mem_q[wr_ptr_b] <= push_i.res_b;
    end
  end

  always_comb begin
    wr_ptr_d = Aw'(wr_ptr_q + Aw'(n_push));
    rd_ptr_d = Aw'(rd_ptr_q + Aw'(pop));
    count_d  = Cw'(count_q + Cw'(n_push) - Cw'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign count_o            = count_q;
  assign res_o.valid        = (count_q != '0);
  assign res_o.out_alpha    = mem_q[rd_ptr_q].px[3];
  assign res_o.out_red      = mem_q[rd_ptr_q].px[2];
  assign res_o.out_green    = mem_q[rd_ptr_q].px[1];
  assign res_o.out_blue     = mem_q[rd_ptr_q].px[0];
  assign res_o.end_of_row   = mem_q[rd_ptr_q].eor;
  assign res_o.end_of_frame = mem_q[rd_ptr_q].eof;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cw'(gbc_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

endmodule

[hdl/gaussian_blur_3x3_clamped.sv]
// 3x3 binomial blur of an ARGB8888 raster stream, edges replicated. One request is taken
// every clock while the queue has room: a request reads both stored rows from one shared
// line memory in the cycle it is accepted and writes them back in the cycle after, and its
// results leave through the result queue. The first row gives no results; each later row
// and the flush row give no result on their first column, one on each later column and
// one more on the last column, held in an eight-entry queue that stalls requests only
// while the result side is blocked. The line memory needs no clearing after reset.
module gaussian_blur_3x3_clamped #(
  parameter int unsigned MaxWidth = gbc_pkg::MAX_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  gbc_in_if.sink                           req_i,
  gbc_out_if.source                        res_o
);

  localparam int unsigned AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CmpW  = gbc_pkg::CMP_W;
  localparam int unsigned HW    = gbc_pkg::HEIGHT_W;
  localparam int unsigned CntW  = gbc_pkg::FIFO_CW + 1;

  logic [gbc_pkg::WIDTH_REG_W-1:0] width_q;
  logic [HW-1:0]                height_q;
  logic [AddrW-1:0]             col_cnt_q, col_cnt_d;
  logic [HW-1:0]                row_cnt_q, row_cnt_d;
  logic [AddrW-1:0]             s1_addr_q;
  gbc_pkg::stage_t              s1_q, s1_d;

  logic [CmpW-1:0]              eff_w, col_ext, col_c;
  logic [HW-1:0]                eff_h;
  logic [AddrW-1:0]             addr;
  logic                         flushing, last, row0, kind_ok, take;
  gbc_pkg::pixel_t              pix;
  gbc_pkg::line_t               rd_line, wr_line;
  gbc_pkg::push_t               push;
  logic [gbc_pkg::FIFO_CW-1:0] fifo_cnt;
  logic [1:0]                   s1_n;
  logic [CntW-1:0]              need;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gbc_pkg::WIDTH_RESET;
      height_q <= gbc_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbc_pkg::CFG_IMAGE_WIDTH:  width_q  <= {1'b0, cfg_data_i[gbc_pkg::WIDTH_W-1:0]};
        gbc_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HW-1:0];
      endcase
    end
  end

  // position and request kind
  always_comb begin
    if (width_q == '0) begin
      eff_w = CmpW'(1);
    end else if (CmpW'(width_q) > CmpW'(MaxWidth)) begin
      eff_w = CmpW'(MaxWidth);
    end else begin
      eff_w = CmpW'(width_q);
    end
    eff_h    = (height_q == '0) ? HW'(1) : height_q;
    col_ext  = CmpW'(col_cnt_q);
    col_c    = (col_ext > CmpW'(MaxWidth - 1)) ? CmpW'(MaxWidth - 1) : col_ext;
    addr     = col_c[AddrW-1:0];
    last     = CmpW'(col_c + CmpW'(1)) >= eff_w;
    flushing = row_cnt_q >= eff_h;
    row0     = !flushing && (row_cnt_q == '0);
    kind_ok  = (req_i.req_type == flushing);
    take     = req_i.valid && req_i.ready && kind_ok;
    pix      = {req_i.pixel_alpha, req_i.pixel_red, req_i.pixel_green, req_i.pixel_blue};
  end

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (take) begin
      if (last) begin
        col_cnt_d = '0;
        row_cnt_d = flushing ? '0 : HW'(row_cnt_q + 1'b1);
      end else begin
        col_cnt_d = AddrW'(addr + 1'b1);
      end
    end
  end

  always_comb begin
    s1_d.valid     = take;
    s1_d.row0      = row0;
    s1_d.flushing  = flushing;
    s1_d.col_zero  = (col_c == '0);
    s1_d.emit_mid  = !row0 && (col_c != '0);
    s1_d.emit_last = !row0 && last;
    s1_d.pix       = pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      s1_q      <= '0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      s1_q      <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_addr_q <= addr;
    end
  end

  // row shift written back: first row fills both stores
  always_comb begin
    wr_line.upper  = s1_q.row0 ? s1_q.pix : rd_line.middle;
    wr_line.middle = s1_q.pix;
  end

  gbc_line_store #(
    .Depth (MaxWidth),
    .AddrW (AddrW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take && !row0),
    .rd_addr_i (addr),
    .wr_en_i   (s1_q.valid && !s1_q.flushing),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_line),
    .rd_data_o (rd_line)
  );

  gbc_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (s1_q),
    .upper_i  (rd_line.upper),
    .middle_i (rd_line.middle),
    .push_o   (push)
  );

  gbc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .count_o (fifo_cnt),
    .res_o   (res_o)
  );

  // room for the request in flight and two more results
  assign s1_n        = s1_q.valid ? ({1'b0, s1_q.emit_mid} + {1'b0, s1_q.emit_last}) : 2'd0;
  assign need        = CntW'({1'b0, fifo_cnt} + CntW'(s1_n) + CntW'(2));
  assign req_i.ready = (need <= CntW'(gbc_pkg::FIFO_DEPTH));

  a_take_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> s1_q.valid)
    else $error("accepted request lost before the window stage");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid |-> (CntW'({1'b0, fifo_cnt} + CntW'(s1_n)) <= CntW'(gbc_pkg::FIFO_DEPTH)))
    else $error("results pushed into a full queue");

  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.end_of_frame) |-> res_o.end_of_row)
    else $error("end of frame without end of row");

endmodule
